FILE: rtl/hsv2rgb_pkg.sv
package hsv2rgb_pkg;

  localparam int HUE_W      = 11;
  localparam int CH_W       = 8;
  localparam int ARGB_W     = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'hFF;

  // Word index of each register, taken from paddr[2]
  localparam logic REG_GAMMA_MODE = 1'b0;

  // Hue sector: which primary leads and which way the second channel ramps
  typedef enum logic [2:0] {
    SEC_RED_YELLOW   = 3'd0,
    SEC_YELLOW_GREEN = 3'd1,
    SEC_GREEN_CYAN   = 3'd2,
    SEC_CYAN_BLUE    = 3'd3,
    SEC_BLUE_MAGENTA = 3'd4,
    SEC_MAGENTA_RED  = 3'd5
  } sector_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  typedef logic [CH_W-1:0] gamma_lut_t [256];

  // floor(x / 255), exact for x up to 255 * 255
  function automatic logic [CH_W-1:0] div255(input logic [15:0] x);
    logic [16:0] sum;
    sum = 17'(x) + 17'(x[15:8]) + 17'd1;
    return sum[15:8];
  endfunction

  // Reduce the coarse hue modulo 6: base-4 digit sums give mod 3, bit 0 gives mod 2
  function automatic sector_t sector_of(input logic [HUE_W-1:0] x);
    logic [4:0] s1;
    logic [2:0] s2;
    logic [2:0] m3;
    s1 = 5'(x[1:0]) + 5'(x[3:2]) + 5'(x[5:4]) + 5'(x[7:6]) + 5'(x[9:8]) + 5'(x[10]);
    s2 = 3'(s1[1:0]) + 3'(s1[3:2]) + 3'(s1[4]);
    if (s2 >= 3'd6) begin
      m3 = s2 - 3'd6;
    end else if (s2 >= 3'd3) begin
      m3 = s2 - 3'd3;
    end else begin
      m3 = s2;
    end
    if (m3[0] == x[0]) begin
      return sector_t'(m3);
    end else begin
      return sector_t'(m3 + 3'd3);
    end
  endfunction

  // Largest y with y^10 <= 255 * i^9, i.e. floor(255 * (i/255)^0.9)
  function automatic gamma_lut_t build_gamma();
    gamma_lut_t lut;
    logic [95:0] rhs;
    logic [95:0] lhs;
    int          y;
    logic        done;
    y = 0;
    for (int i = 0; i < 256; i++) begin
      rhs = 96'd255;
      for (int n = 0; n < 9; n++) begin
        rhs = rhs * 96'(i);
      end
      done = 1'b0;
      for (int step = 0; step < 256; step++) begin
        if (!done && y < 255) begin
          lhs = 96'd1;
          for (int n = 0; n < 10; n++) begin
            lhs = lhs * 96'(y + 1);
          end
          if (lhs <= rhs) begin
            y = y + 1;
          end else begin
            done = 1'b1;
          end
        end
      end
      lut[i] = 8'(y);
    end
    return lut;
  endfunction

  localparam gamma_lut_t GAMMA_LUT = build_gamma();

endpackage

FILE: rtl/hsv2rgb_if.sv
interface hsv2rgb_pix_if;
  logic                             valid;
  logic                             ready;
  logic [hsv2rgb_pkg::HUE_W-1:0]    hue;
  logic [hsv2rgb_pkg::CH_W-1:0]     saturation;
  logic [hsv2rgb_pkg::CH_W-1:0]     value;

  modport source (output valid, output hue, output saturation, output value, input ready);
  modport sink   (input valid, input hue, input saturation, input value, output ready);
endinterface

interface hsv2rgb_rgb_if;
  logic                             valid;
  logic                             ready;
  logic [hsv2rgb_pkg::CH_W-1:0]     red;
  logic [hsv2rgb_pkg::CH_W-1:0]     green;
  logic [hsv2rgb_pkg::CH_W-1:0]     blue;
  logic [hsv2rgb_pkg::ARGB_W-1:0]   packed_argb;

  modport source (output valid, output red, output green, output blue,
                  output packed_argb, input ready);
  modport sink   (input valid, input red, input green, input blue,
                  input packed_argb, output ready);
endinterface

FILE: rtl/hsv2rgb_apb.sv
module hsv2rgb_apb (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [hsv2rgb_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [hsv2rgb_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [hsv2rgb_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                                pready,
  output logic                                gamma_mode
);

  logic wr_gamma;

  assign pready   = 1'b1;
  assign wr_gamma = psel && penable && pwrite && (paddr[2] == hsv2rgb_pkg::REG_GAMMA_MODE);

  always_ff @(posedge clk) begin
    if (rst) begin
      gamma_mode <= 1'b0;
    end else if (wr_gamma) begin
      gamma_mode <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == hsv2rgb_pkg::REG_GAMMA_MODE) begin
      prdata[0] = gamma_mode;
    end
  end

endmodule

FILE: rtl/hsv2rgb_arith.sv
module hsv2rgb_arith #(
  parameter int HUE_STEP_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  hsv2rgb_pix_if.sink          pix,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output hsv2rgb_pkg::rgb_t    dn_pix
);

  localparam int HSB = HUE_STEP_BITS;
  localparam int CW  = hsv2rgb_pkg::CH_W;
  localparam int TW  = HSB + CW;        // s*k + (255-s)*D is at most 255*D
  localparam int NW  = TW + CW;         // v times the above
  localparam int HUE_W_L = hsv2rgb_pkg::HUE_W;

  localparam logic [HSB:0] STEP_ONE = {1'b1, {HSB{1'b0}}};

  // stage 1: sector and ramp
  logic                          s1_valid;
  hsv2rgb_pkg::sector_t          s1_sector;
  logic [HSB:0]                  s1_ramp;
  logic [CW-1:0]                 s1_sat;
  logic [CW-1:0]                 s1_val;
  // stage 2: first products
  logic                          s2_valid;
  hsv2rgb_pkg::sector_t          s2_sector;
  logic [CW-1:0]                 s2_val;
  logic [TW-1:0]                 s2_mix;
  logic [15:0]                   s2_prod0;
  // stage 3: second channel numerator, zero channel
  logic                          s3_valid;
  hsv2rgb_pkg::sector_t          s3_sector;
  logic [CW-1:0]                 s3_val;
  logic [NW-1:0]                 s3_num;
  logic [CW-1:0]                 s3_zero;
  // stage 4: ordered channels
  logic                          s4_valid;
  hsv2rgb_pkg::rgb_t             s4_pix;

  logic                          en1, en2, en3, en4;
  logic [HUE_W_L-1:0]            coarse;
  logic [HSB-1:0]                frac;
  hsv2rgb_pkg::sector_t          sector;
  logic [HSB:0]                  ramp;
  logic [CW-1:0]                 sat_inv;
  logic [CW-1:0]                 ch_x;
  hsv2rgb_pkg::rgb_t             order;

  // a stage loads when it is empty or its successor moves
  assign en4       = !s4_valid || dn_ready;
  assign en3       = !s3_valid || en4;
  assign en2       = !s2_valid || en3;
  assign en1       = !s1_valid || en2;
  assign pix.ready = en1;

  assign coarse = pix.hue >> HSB;
  assign frac   = HSB'(pix.hue);
  assign sector = hsv2rgb_pkg::sector_of(coarse);
  assign ramp   = sector[0] ? (STEP_ONE - (HSB + 1)'(frac)) : (HSB + 1)'(frac);

  assign sat_inv = ~s1_sat;

  assign ch_x = hsv2rgb_pkg::div255(s3_num[NW-1:HSB]);

  always_comb begin
    unique case (s3_sector)
      hsv2rgb_pkg::SEC_RED_YELLOW:   order = '{red: s3_val,  green: ch_x,    blue: s3_zero};
      hsv2rgb_pkg::SEC_YELLOW_GREEN: order = '{red: ch_x,    green: s3_val,  blue: s3_zero};
      hsv2rgb_pkg::SEC_GREEN_CYAN:   order = '{red: s3_zero, green: s3_val,  blue: ch_x};
      hsv2rgb_pkg::SEC_CYAN_BLUE:    order = '{red: s3_zero, green: ch_x,    blue: s3_val};
      hsv2rgb_pkg::SEC_BLUE_MAGENTA: order = '{red: ch_x,    green: s3_zero, blue: s3_val};
      default:                       order = '{red: s3_val,  green: s3_zero, blue: ch_x};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else begin
      if (en1) s1_valid <= pix.valid;
      if (en2) s2_valid <= s1_valid;
      if (en3) s3_valid <= s2_valid;
      if (en4) s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_sector <= sector;
      s1_ramp   <= ramp;
      s1_sat    <= pix.saturation;
      s1_val    <= pix.value;
    end
    if (en2) begin
      s2_sector <= s1_sector;
      s2_val    <= s1_val;
      s2_mix    <= TW'(s1_sat) * TW'(s1_ramp) + {sat_inv, {HSB{1'b0}}};
      s2_prod0  <= 16'(s1_val) * 16'(sat_inv);
    end
    if (en3) begin
      s3_sector <= s2_sector;
      s3_val    <= s2_val;
      s3_num    <= NW'(s2_val) * NW'(s2_mix);
      s3_zero   <= hsv2rgb_pkg::div255(s2_prod0);
    end
    if (en4) begin
      s4_pix <= order;
    end
  end

  assign dn_valid = s4_valid;
  assign dn_pix   = s4_pix;

endmodule

FILE: rtl/hsv2rgb_gamma.sv
module hsv2rgb_gamma (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 gamma_mode,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  hsv2rgb_pkg::rgb_t    up_pix,
  hsv2rgb_rgb_if.source        rgb
);

  logic                         valid;
  logic [hsv2rgb_pkg::CH_W-1:0] red;
  logic [hsv2rgb_pkg::CH_W-1:0] green;
  logic [hsv2rgb_pkg::CH_W-1:0] blue;
  logic                         en;

  assign en       = !valid || rgb.ready;
  assign up_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      red   <= gamma_mode ? hsv2rgb_pkg::GAMMA_LUT[up_pix.red]   : up_pix.red;
      green <= gamma_mode ? hsv2rgb_pkg::GAMMA_LUT[up_pix.green] : up_pix.green;
      blue  <= gamma_mode ? hsv2rgb_pkg::GAMMA_LUT[up_pix.blue]  : up_pix.blue;
    end
  end

  assign rgb.valid       = valid;
  assign rgb.red         = red;
  assign rgb.green       = green;
  assign rgb.blue        = blue;
  assign rgb.packed_argb = {hsv2rgb_pkg::ALPHA_OPAQUE, red, green, blue};

endmodule

FILE: rtl/hsv_to_rgb_pixel_converter.sv
// HSV to RGB pixel converter. Each beat on pix carries one pixel: hue as
// sector * 2^HUE_STEP_BITS + fraction (sector taken modulo 6, so hue wraps
// around the circle), saturation and value as fractions of 255. Each beat on
// rgb carries the truncated red, green and blue channels and the same bytes
// packed as ARGB with alpha 0xFF. The block takes one pixel every clock cycle
// while the rgb sink stays ready, and each result passes through five register
// stages (sector and ramp, first products, second product and zero channel,
// channel ordering, gamma table and output register). Every stage drains into
// the next one as soon as that one is empty or moving, so bubbles close up and
// a stalled sink holds at most five pixels before pix.ready drops. Register
// gamma_mode (word 0, bit 0, reset 0) maps each channel through
// floor(255 * (c/255)^0.9); write it only while no pixel is in flight.
module hsv_to_rgb_pixel_converter #(
  parameter int HUE_STEP_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [hsv2rgb_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [hsv2rgb_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [hsv2rgb_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                                pready,
  hsv2rgb_pix_if.sink                         pix,
  hsv2rgb_rgb_if.source                       rgb
);

  logic              gamma_mode;
  // arithmetic pipeline to gamma/output stage
  logic              mid_valid;
  logic              mid_ready;
  hsv2rgb_pkg::rgb_t mid_pix;

  // Hold the single config register
  hsv2rgb_apb u_apb (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .gamma_mode (gamma_mode)
  );

  // Compute value, zero and ramp channels, then order them by sector
  hsv2rgb_arith #(
    .HUE_STEP_BITS (HUE_STEP_BITS)
  ) u_arith (
    .clk      (clk),
    .rst      (rst),
    .pix      (pix),
    .dn_valid (mid_valid),
    .dn_ready (mid_ready),
    .dn_pix   (mid_pix)
  );

  // Apply the optional gamma table and register the result beat
  hsv2rgb_gamma u_gamma (
    .clk        (clk),
    .rst        (rst),
    .gamma_mode (gamma_mode),
    .up_valid   (mid_valid),
    .up_ready   (mid_ready),
    .up_pix     (mid_pix),
    .rgb        (rgb)
  );

  // Nothing leaves the pipeline right after reset
  a_quiet_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !rgb.valid)
    else $error("result beat right after reset");

  // An empty output stage means every stage can advance
  a_empty_takes_pixel: assert property (@(posedge clk) disable iff (rst)
    !rgb.valid |-> pix.ready)
    else $error("pipeline refused a pixel with the output stage empty");

  // A gamma_mode write reads back on the next cycle
  a_cfg_readback: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && pready && (paddr[2] == hsv2rgb_pkg::REG_GAMMA_MODE))
    |=> ((paddr[2] != hsv2rgb_pkg::REG_GAMMA_MODE) || (prdata[0] == $past(pwdata[0]))))
    else $error("gamma_mode readback mismatch");

endmodule
